>>> sv/tvs_pkg.sv
package tvs_pkg;

	localparam int FRAC_W = 16;
	localparam int CRD_W = FRAC_W + 1;
	localparam int WGT_W = FRAC_W + 1;
	localparam int IDX_W = 6;
	localparam int LD_W = 5;
	localparam int BYTE_W = 8;
	localparam int OUT_W = 16;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int CNT_W = 3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [PADDR_W-3:0] REG_X_SIZE = 2'd0;
	localparam logic [PADDR_W-3:0] REG_Y_SIZE = 2'd1;
	localparam logic [PADDR_W-3:0] REG_Z_SIZE = 2'd2;

	localparam logic [IDX_W-1:0] SIZE_RST = 6'd32;
	localparam logic [CNT_W-1:0] LAST_CORNER = 3'd7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_QUERY
	} state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic [WGT_W-1:0] wx;
		logic [WGT_W-1:0] wy;
		logic [WGT_W-1:0] wz;
	} corner_t;

endpackage

>>> sv/tvs_axis.sv
module tvs_axis #(
	parameter int MAX_DIM = 32
) (
	input  logic clk,
	input  logic capture,
	input  logic signed [tvs_pkg::CRD_W-1:0] coord,
	input  logic [tvs_pkg::IDX_W-1:0] size_reg,
	output logic [tvs_pkg::IDX_W-1:0] idx_lo,
	output logic [tvs_pkg::IDX_W-1:0] idx_hi,
	output logic [tvs_pkg::WGT_W-1:0] w_lo,
	output logic [tvs_pkg::WGT_W-1:0] w_hi
);

	localparam int IW = tvs_pkg::IDX_W;
	localparam int CW = tvs_pkg::CRD_W;
	localparam int FW = tvs_pkg::FRAC_W;
	localparam int WW = tvs_pkg::WGT_W;
	localparam int T_W = CW + IW;
	localparam int SZ_CAP = (MAX_DIM > (2**IW) - 1) ? (2**IW) - 1 : MAX_DIM;
	localparam logic [IW-1:0] SZ_MAX = IW'(SZ_CAP);
	localparam logic signed [CW-1:0] CRD_HI = CW'(2**(FW-1));
	localparam logic signed [CW-1:0] CRD_LO = -CRD_HI;
	localparam logic [CW-1:0] HALF = CW'(2**(FW-1));
	localparam logic [WW-1:0] ONE = WW'(2**FW);

	logic [IW-1:0] size_eff;
	logic [IW-1:0] size_m1;
	logic signed [CW-1:0] crd_sat;
	logic [CW-1:0] u;
	logic [T_W-1:0] t;
	logic [IW:0] base;
	logic [IW:0] base_p1;
	logic [FW-1:0] frac;
	logic [IW-1:0] lo_d;
	logic [IW-1:0] hi_d;

	always_comb begin
		if (size_reg == '0) begin
			size_eff = IW'(1);
		end else if (size_reg > SZ_MAX) begin
			size_eff = SZ_MAX;
		end else begin
			size_eff = size_reg;
		end
		size_m1 = size_eff - IW'(1);

		if (coord < CRD_LO) begin
			crd_sat = CRD_LO;
		end else if (coord > CRD_HI) begin
			crd_sat = CRD_HI;
		end else begin
			crd_sat = coord;
		end
		u = unsigned'(crd_sat) + HALF;

		t = T_W'(u) * T_W'(size_eff);
		base = t[T_W-1:FW];
		frac = t[FW-1:0];
		base_p1 = base + (IW+1)'(1);

		lo_d = (base > {1'b0, size_m1}) ? size_m1 : base[IW-1:0];
		hi_d = (base_p1 > {1'b0, size_m1}) ? size_m1 : base_p1[IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			idx_lo <= lo_d;
			idx_hi <= hi_d;
			w_lo <= ONE - {1'b0, frac};
			w_hi <= {1'b0, frac};
		end
	end

endmodule

>>> sv/tvs_mem.sv
module tvs_mem #(
	parameter int DEPTH = 32768,
	parameter int AW = 15
) (
	input  logic clk,
	input  logic en,
	input  logic we,
	input  logic [AW-1:0] addr,
	input  logic [tvs_pkg::BYTE_W-1:0] wdata,
	output logic [tvs_pkg::BYTE_W-1:0] rdata
);

	logic [tvs_pkg::BYTE_W-1:0] store_q [DEPTH];
	logic [tvs_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				store_q[addr] <= wdata;
			end else begin
				rdata_q <= store_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/tvs_blend.sv
module tvs_blend (
	input  logic clk,
	input  logic arst_n,
	input  tvs_pkg::corner_t crn,
	input  logic [tvs_pkg::BYTE_W-1:0] rdata,
	output logic done,
	output logic signed [tvs_pkg::OUT_W-1:0] field_value
);

	localparam int FW = tvs_pkg::FRAC_W;
	localparam int WW = tvs_pkg::WGT_W;
	localparam int M1_W = tvs_pkg::BYTE_W + WW;
	localparam int M2_W = tvs_pkg::BYTE_W + 2 * FW;
	localparam int M3_W = tvs_pkg::BYTE_W + 3 * FW;
	localparam int DIV_SH = 2 * FW + 1;
	localparam int N_W = M3_W - DIV_SH;
	localparam int RECIP_W = 24;
	localparam int RECIP_SH = 31;
	localparam int P_W = N_W + RECIP_W;
	localparam int OW = tvs_pkg::OUT_W;
	localparam logic [M3_W-1:0] RND = M3_W'(255) << (2 * FW);
	localparam logic [RECIP_W-1:0] RECIP = 24'd8421505;
	localparam logic [OW-1:0] OFFSET = OW'(2**(FW-2));

	logic vld_s2, fst_s2, lst_s2;
	logic vld_s3, fst_s3, lst_s3;
	logic vld_s4, fst_s4, lst_s4;
	logic fin_s5, vld_s6, vld_s7;
	logic [M1_W-1:0] m1_s2;
	logic [WW-1:0] wy_s2, wz_s2, wz_s3;
	logic [M2_W-1:0] m2_s3;
	logic [M3_W-1:0] m3_s4;
	logic [M3_W-1:0] acc_q;
	logic [N_W-1:0] n_s6;
	logic [P_W-1:0] p_s7;
	logic done_q;
	logic signed [OW-1:0] field_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			fin_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s2 <= crn.valid;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			fin_s5 <= vld_s4 & lst_s4;
			vld_s6 <= fin_s5;
			vld_s7 <= vld_s6;
			done_q <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		fst_s2 <= crn.first;
		lst_s2 <= crn.last;
		m1_s2 <= M1_W'(rdata) * M1_W'(crn.wx);
		wy_s2 <= crn.wy;
		wz_s2 <= crn.wz;

		fst_s3 <= fst_s2;
		lst_s3 <= lst_s2;
		m2_s3 <= M2_W'(m1_s2) * M2_W'(wy_s2);
		wz_s3 <= wz_s2;

		fst_s4 <= fst_s3;
		lst_s4 <= lst_s3;
		m3_s4 <= M3_W'(m2_s3) * M3_W'(wz_s3);

		if (vld_s4) begin
			acc_q <= fst_s4 ? m3_s4 : acc_q + m3_s4;
		end

		n_s6 <= N_W'((acc_q + RND) >> DIV_SH);
		p_s7 <= P_W'(n_s6) * P_W'(RECIP);
		field_value_q <= signed'(p_s7[P_W-1:RECIP_SH] - OFFSET);
	end

	assign done = done_q;
	assign field_value = field_value_q;

endmodule

>>> sv/trilinear_volume_sampler_unit.sv
// channel   dir     signals
// request   in      start, opcode, load_x/y/z, load_byte, query_x/y/z (busy is out)
// result    out     done, field_value
// config    in/out  psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// a query is taken, then busy holds while the eight corners are
// read from the single volume memory port, one per cycle; busy drops on the last read
// a load is taken, then busy holds while the byte is written, if its coordinates are in range
// done and field_value appear at the end of the blend pipeline, one cycle only
// reset sets all sizes to 32; volume contents stay undefined until loaded
module trilinear_volume_sampler_unit #(
	parameter int MAX_X = 32,
	parameter int MAX_Y = 32,
	parameter int MAX_Z = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tvs_pkg::PADDR_W-1:0] paddr,
	input  logic [tvs_pkg::PDATA_W-1:0] pwdata,
	output logic [tvs_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	input  logic start,
	output logic busy,
	input  logic opcode,
	input  logic [tvs_pkg::LD_W-1:0] load_x,
	input  logic [tvs_pkg::LD_W-1:0] load_y,
	input  logic [tvs_pkg::LD_W-1:0] load_z,
	input  logic [tvs_pkg::BYTE_W-1:0] load_byte,
	input  logic signed [tvs_pkg::CRD_W-1:0] query_x,
	input  logic signed [tvs_pkg::CRD_W-1:0] query_y,
	input  logic signed [tvs_pkg::CRD_W-1:0] query_z,
	output logic done,
	output logic signed [tvs_pkg::OUT_W-1:0] field_value
);

	localparam int IW = tvs_pkg::IDX_W;
	localparam int WW = tvs_pkg::WGT_W;
	localparam int PW = tvs_pkg::PDATA_W;
	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] STRIDE_Y = AW'(MAX_X);
	localparam logic [AW-1:0] STRIDE_Z = AW'(MAX_X * MAX_Y);

	tvs_pkg::state_t state_q, state_d;
	logic [tvs_pkg::CNT_W-1:0] cnt_q;
	logic accept;
	logic q_accept;
	logic l_accept;
	logic rd_issue;
	logic wr_issue;
	logic cfg_wr;

	logic [IW-1:0] x_size_q, y_size_q, z_size_q;

	logic [AW-1:0] ld_addr_q;
	logic [tvs_pkg::BYTE_W-1:0] ld_byte_q;
	logic ld_ok_q;
	logic [AW-1:0] ld_addr_d;
	logic ld_ok_d;

	logic [IW-1:0] ix_lo, ix_hi, iy_lo, iy_hi, iz_lo, iz_hi;
	logic [WW-1:0] wx_lo, wx_hi, wy_lo, wy_hi, wz_lo, wz_hi;
	logic [IW-1:0] xi, yi, zi;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] mem_addr;
	logic [tvs_pkg::BYTE_W-1:0] mem_rdata;
	tvs_pkg::corner_t crn_s1;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_size_q <= tvs_pkg::SIZE_RST;
			y_size_q <= tvs_pkg::SIZE_RST;
			z_size_q <= tvs_pkg::SIZE_RST;
		end else if (cfg_wr) begin
			case (paddr[tvs_pkg::PADDR_W-1:2])
				tvs_pkg::REG_X_SIZE: x_size_q <= pwdata[IW-1:0];
				tvs_pkg::REG_Y_SIZE: y_size_q <= pwdata[IW-1:0];
				tvs_pkg::REG_Z_SIZE: z_size_q <= pwdata[IW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[tvs_pkg::PADDR_W-1:2])
			tvs_pkg::REG_X_SIZE: prdata = PW'(x_size_q);
			tvs_pkg::REG_Y_SIZE: prdata = PW'(y_size_q);
			tvs_pkg::REG_Z_SIZE: prdata = PW'(z_size_q);
			default: prdata = '0;
		endcase
	end

	// sequencer
	assign accept = start & ~busy;
	assign q_accept = accept & (opcode == tvs_pkg::OP_QUERY);
	assign l_accept = accept & (opcode == tvs_pkg::OP_LOAD);

	always_comb begin
		case (state_q)
			tvs_pkg::ST_LOAD: state_d = tvs_pkg::ST_IDLE;
			tvs_pkg::ST_QUERY: begin
				state_d = (cnt_q == tvs_pkg::LAST_CORNER) ? tvs_pkg::ST_IDLE : tvs_pkg::ST_QUERY;
			end
			default: state_d = tvs_pkg::ST_IDLE;
		endcase
		if (q_accept) begin
			state_d = tvs_pkg::ST_QUERY;
		end else if (l_accept) begin
			state_d = tvs_pkg::ST_LOAD;
		end
	end

	always_comb begin
		busy = 1'b0;
		rd_issue = 1'b0;
		wr_issue = 1'b0;
		case (state_q)
			tvs_pkg::ST_LOAD: begin
				busy = 1'b1;
				wr_issue = ld_ok_q;
			end
			tvs_pkg::ST_QUERY: begin
				busy = (cnt_q != tvs_pkg::LAST_CORNER);
				rd_issue = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tvs_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_issue) begin
				cnt_q <= cnt_q + tvs_pkg::CNT_W'(1);
			end
		end
	end

	// load request capture
	always_comb begin
		ld_ok_d = (32'(load_x) < MAX_X) && (32'(load_y) < MAX_Y) && (32'(load_z) < MAX_Z);
		ld_addr_d = AW'(load_x) + AW'(load_y) * STRIDE_Y + AW'(load_z) * STRIDE_Z;
	end

	always_ff @(posedge clk) begin
		if (l_accept) begin
			ld_addr_q <= ld_addr_d;
			ld_byte_q <= load_byte;
			ld_ok_q <= ld_ok_d;
		end
	end

	tvs_axis #(.MAX_DIM(MAX_X)) u_axis_x (
		.clk(clk), .capture(q_accept), .coord(query_x), .size_reg(x_size_q),
		.idx_lo(ix_lo), .idx_hi(ix_hi), .w_lo(wx_lo), .w_hi(wx_hi)
	);

	tvs_axis #(.MAX_DIM(MAX_Y)) u_axis_y (
		.clk(clk), .capture(q_accept), .coord(query_y), .size_reg(y_size_q),
		.idx_lo(iy_lo), .idx_hi(iy_hi), .w_lo(wy_lo), .w_hi(wy_hi)
	);

	tvs_axis #(.MAX_DIM(MAX_Z)) u_axis_z (
		.clk(clk), .capture(q_accept), .coord(query_z), .size_reg(z_size_q),
		.idx_lo(iz_lo), .idx_hi(iz_hi), .w_lo(wz_lo), .w_hi(wz_hi)
	);

	// corner address, bit 0 picks x, bit 1 y, bit 2 z
	always_comb begin
		xi = cnt_q[0] ? ix_hi : ix_lo;
		yi = cnt_q[1] ? iy_hi : iy_lo;
		zi = cnt_q[2] ? iz_hi : iz_lo;
		rd_addr = AW'(xi) + AW'(yi) * STRIDE_Y + AW'(zi) * STRIDE_Z;
		mem_addr = wr_issue ? ld_addr_q : rd_addr;
	end

	tvs_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk(clk),
		.en(rd_issue | wr_issue),
		.we(wr_issue),
		.addr(mem_addr),
		.wdata(ld_byte_q),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crn_s1 <= '0;
		end else begin
			crn_s1.valid <= rd_issue;
			crn_s1.first <= (cnt_q == '0);
			crn_s1.last <= (cnt_q == tvs_pkg::LAST_CORNER);
			crn_s1.wx <= cnt_q[0] ? wx_hi : wx_lo;
			crn_s1.wy <= cnt_q[1] ? wy_hi : wy_lo;
			crn_s1.wz <= cnt_q[2] ? wz_hi : wz_lo;
		end
	end

	tvs_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.crn(crn_s1),
		.rdata(mem_rdata),
		.done(done),
		.field_value(field_value)
	);

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		q_accept |=> (state_q == tvs_pkg::ST_QUERY) && (cnt_q == '0))
		else $error("query request did not start the corner reads");

	a_load_writes: assert property (@(posedge clk) disable iff (!arst_n)
		l_accept |=> (state_q == tvs_pkg::ST_LOAD) && !rd_issue)
		else $error("load request did not go to the write cycle");

	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe on back to back cycles");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (field_value >= -16'sd16384) && (field_value <= 16'sd16384))
		else $error("field_value outside of the sample range");

endmodule
